@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ppb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppb_pkg
// Types and constants of the page programming buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package ppb_pkg;

  localparam int BUFFERS    = 4;
  localparam int PAGE_BYTES = 128;
  localparam int LANE_BYTES = 8;

  localparam int WORDS     = PAGE_BYTES / LANE_BYTES;
  localparam int BUF_W     = $clog2(BUFFERS);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int LANE_W    = $clog2(LANE_BYTES);
  localparam int WORD_W    = $clog2(WORDS);
  localparam int RAM_DEPTH = BUFFERS * WORDS;
  localparam int RAM_AW    = BUF_W + WORD_W;
  localparam int CNT_W     = $clog2(BUFFERS + 1);

  typedef enum logic [2:0] {
    CMD_ACQ_IN   = 3'd0,
    CMD_CHECK    = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_ACQ_PROG = 3'd3,
    CMD_RELEASE  = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FILLING = 2'd2,
    ST_TOPROG  = 2'd3
  } slot_t;

  typedef enum logic [1:0] {
    LOP_NONE  = 2'd0,
    LOP_WRITE = 2'd1,
    LOP_READ  = 2'd2,
    LOP_SWEEP = 2'd3
  } lop_kind_t;

  // operation broadcast to every byte lane
  typedef struct packed {
    lop_kind_t          op;
    logic [RAM_AW-1:0]  addr;
    logic               flag;
    logic [OFF_W-1:0]   off;
    logic [3:0]         n;
    logic [63:0]        data;
  } lane_op_t;

endpackage

`default_nettype wire

@@ rtl/ppb_if.sv @@
// ----------------------------------------------------------------------------
// ppb_req_if / ppb_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  buffer_index;
  logic [31:0] byte_address;
  logic [3:0]  byte_count;
  logic [63:0] write_data;
  logic        submit;
  logic [3:0]  word_offset;

  modport source (output valid, command, buffer_index, byte_address, byte_count,
                  write_data, submit, word_offset, input ready);
  modport sink (input valid, command, buffer_index, byte_address, byte_count,
                write_data, submit, word_offset, output ready);
endinterface

interface ppb_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  chosen_index;
  logic [3:0]  bytes_copied;
  logic [31:0] page_address;
  logic [63:0] read_data;
  logic [1:0]  buffer_state;
  logic [2:0]  free_count;
  logic        error;

  modport source (output valid, found, chosen_index, bytes_copied, page_address,
                  read_data, buffer_state, free_count, error, input ready);
  modport sink (input valid, found, chosen_index, bytes_copied, page_address,
                read_data, buffer_state, free_count, error, output ready);
endinterface

`default_nettype wire

@@ rtl/ppb_ram.sv @@
// ----------------------------------------------------------------------------
// ppb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppb_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ppb_lane.sv @@
// ----------------------------------------------------------------------------
// ppb_lane
// One byte lane: stores byte j of every page word with its unwritten flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ppb_lane import ppb_pkg::*; (
  input  wire logic              clk,
  input  wire logic [LANE_W-1:0] lane_id,
  input  wire lane_op_t          lop,
  output      logic [7:0]        rd_byte
);

  logic [LANE_W-1:0] pick;
  logic [WORD_W-1:0] word;
  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [8:0]        wdata;
  logic [8:0]        q;

  // which byte of the offered data lands in this lane, and in which word
  always_comb begin
    pick  = lane_id - lop.off[LANE_W-1:0];
    word  = lop.off[OFF_W-1:LANE_W] + WORD_W'(lane_id < lop.off[LANE_W-1:0]);
    we    = 1'b0;
    waddr = lop.addr;
    wdata = {lop.flag, 8'h00};
    case (lop.op)
      LOP_WRITE: begin
        we    = {1'b0, pick} < lop.n;
        waddr = {lop.addr[RAM_AW-1 -: BUF_W], word};
        wdata = {1'b0, lop.data[{pick, 3'b000} +: 8]};
      end
      LOP_SWEEP: we = 1'b1;
      default:   we = 1'b0;
    endcase
  end

  ppb_ram #(.WIDTH(9), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (lop.addr),
    .rdata (q)
  );

  // unwritten bytes read back as erased flash
  assign rd_byte = q[8] ? 8'hFF : q[7:0];

endmodule

`default_nettype wire

@@ rtl/page_program_buffer_pool.sv @@
// ----------------------------------------------------------------------------
// page_program_buffer_pool
// Pool of flash page buffers: slot states, page addresses, byte-lane storage.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// req      in   valid/ready   command, index, address, count, data, submit, word
// rsp      out  valid/ready   found, index, copied, page, data, state, count, error
//
// One item at a time: most commands register their result when accepted, read
// adds S_READ (registered lane RAM read), acquire input adds S_FILL (16-word flag sweep).
// After reset a clearing pass runs over all 64 lane RAM words, req not ready.
// A result waits in the output register until taken; req is held off meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module page_program_buffer_pool import ppb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  ppb_req_if.sink  req,
  ppb_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_FILL  = 5'b01000,
    S_DONE  = 5'b10000
  } fsm_t;

  fsm_t              state, state_next;
  slot_t             slot_state [BUFFERS];
  logic [31:0]       slot_page [BUFFERS];
  logic [CNT_W-1:0]  free_buffers;
  logic [RAM_AW-1:0] sweep;
  logic [BUF_W-1:0]  fill_buf;
  logic              rd_blank;

  logic              accept;
  logic [BUF_W-1:0]  idx;
  logic              idx_ok;
  slot_t             st;
  logic [31:0]       page_in;
  logic [OFF_W-1:0]  off;
  logic [OFF_W:0]    room;
  logic [3:0]        cnt_sat;
  logic [3:0]        n;
  logic              free_hit, prog_hit;
  logic [BUF_W-1:0]  free_idx, prog_idx;

  slot_t             st_new;
  logic [31:0]       pa_new;
  logic              wr_slot, wr_page;
  logic              inc_free, dec_free;
  logic              tgt_ok;
  logic [BUF_W-1:0]  tgt;
  logic              found, err, start_fill, start_read;
  logic [3:0]        copied;
  lane_op_t          lop;
  logic [7:0]        lane_byte [LANE_BYTES];
  logic [63:0]       merged;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);

  // request decode
  always_comb begin
    idx     = req.buffer_index[BUF_W-1:0];
    idx_ok  = int'(req.buffer_index) < BUFFERS;
    st      = slot_state[idx];
    page_in = req.byte_address & ~32'(PAGE_BYTES - 1);
    off     = req.byte_address[OFF_W-1:0];
    room    = (OFF_W+1)'(PAGE_BYTES) - {1'b0, off};
    cnt_sat = (req.byte_count > 4'(LANE_BYTES)) ? 4'(LANE_BYTES) : req.byte_count;
    n       = ({{(OFF_W-3){1'b0}}, cnt_sat} > room) ? room[3:0] : cnt_sat;
  end

  // highest-index slot in each searched state
  always_comb begin
    free_hit = 1'b0;
    prog_hit = 1'b0;
    free_idx = '0;
    prog_idx = '0;
    for (int u = 0; u < BUFFERS; u++) begin
      if (slot_state[u] == ST_FREE) begin
        free_hit = 1'b1;
        free_idx = BUF_W'(u);
      end
      if (slot_state[u] == ST_TOPROG) begin
        prog_hit = 1'b1;
        prog_idx = BUF_W'(u);
      end
    end
  end

  // command evaluation
  always_comb begin
    st_new     = st;
    pa_new     = slot_page[idx];
    wr_slot    = 1'b0;
    wr_page    = 1'b0;
    inc_free   = 1'b0;
    dec_free   = 1'b0;
    tgt_ok     = 1'b0;
    tgt        = idx;
    found      = 1'b0;
    err        = 1'b0;
    copied     = '0;
    start_fill = 1'b0;
    start_read = 1'b0;
    case (req.command)
      CMD_ACQ_IN: begin
        if (free_hit) begin
          tgt_ok     = 1'b1;
          tgt        = free_idx;
          found      = 1'b1;
          st_new     = ST_EMPTY;
          pa_new     = slot_page[free_idx];
          wr_slot    = 1'b1;
          dec_free   = free_buffers != '0;
          start_fill = 1'b1;
        end
      end
      CMD_ACQ_PROG: begin
        if (prog_hit) begin
          tgt_ok = 1'b1;
          tgt    = prog_idx;
          found  = 1'b1;
          st_new = ST_TOPROG;
          pa_new = slot_page[prog_idx];
        end
      end
      CMD_CHECK, CMD_WRITE, CMD_RELEASE, CMD_READ: begin
        if (!idx_ok) begin
          err = 1'b1;
        end else begin
          tgt_ok = 1'b1;
          case (req.command)
            CMD_CHECK: begin
              if (st == ST_EMPTY) begin
                pa_new  = page_in;
                wr_page = 1'b1;
                found   = 1'b1;
              end else if (st == ST_FILLING) begin
                found = slot_page[idx] == page_in;
              end else begin
                err = 1'b1;
              end
            end
            CMD_WRITE: begin
              if (st == ST_FREE || st == ST_TOPROG) begin
                err = 1'b1;
              end else begin
                if (st == ST_EMPTY) begin
                  pa_new  = page_in;
                  wr_page = 1'b1;
                  st_new  = ST_FILLING;
                  wr_slot = 1'b1;
                end
                if (page_in == pa_new) begin
                  copied = n;
                end
              end
            end
            CMD_RELEASE: begin
              if (req.submit) begin
                if (st == ST_FILLING) begin
                  st_new  = ST_TOPROG;
                  wr_slot = 1'b1;
                end else begin
                  err = 1'b1;
                end
              end else if (st == ST_FREE) begin
                err = 1'b1;
              end else begin
                st_new   = ST_FREE;
                wr_slot  = 1'b1;
                inc_free = int'(free_buffers) < BUFFERS;
              end
            end
            default: start_read = 1'b1;
          endcase
        end
      end
      default: err = 1'b1;
    endcase
  end

  // operation issued to the byte lanes
  always_comb begin
    lop      = '0;
    lop.op   = LOP_NONE;
    lop.off  = off;
    lop.n    = copied;
    lop.data = req.write_data;
    if (state == S_CLEAR) begin
      lop.op   = LOP_SWEEP;
      lop.addr = sweep;
      lop.flag = 1'b0;
    end else if (state == S_FILL) begin
      lop.op   = LOP_SWEEP;
      lop.addr = {fill_buf, sweep[WORD_W-1:0]};
      lop.flag = 1'b1;
    end else if (accept && start_read) begin
      lop.op   = LOP_READ;
      lop.addr = {idx, req.word_offset[WORD_W-1:0]};
    end else if (accept && copied != '0) begin
      lop.op   = LOP_WRITE;
      lop.addr = {idx, {WORD_W{1'b0}}};
    end
  end

  // byte lanes
  for (genvar j = 0; j < LANE_BYTES; j++) begin : g_lane
    ppb_lane u_lane (
      .clk     (clk),
      .lane_id (LANE_W'(j)),
      .lop     (lop),
      .rd_byte (lane_byte[j])
    );
    assign merged[j*8 +: 8] = lane_byte[j];
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sweep == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (start_fill)      state_next = S_FILL;
          else if (start_read) state_next = S_READ;
          else                 state_next = S_DONE;
        end
      end
      S_READ: state_next = S_DONE;
      S_FILL: if (sweep[WORD_W-1:0] == '1) state_next = S_DONE;
      S_DONE: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep        <= '0;
      free_buffers <= CNT_W'(BUFFERS);
      for (int u = 0; u < BUFFERS; u++) begin
        slot_state[u] <= ST_FREE;
        slot_page[u]  <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_FILL) begin
        sweep <= sweep + 1'b1;
      end else begin
        sweep <= '0;
      end
      if (accept) begin
        if (wr_slot) slot_state[tgt] <= st_new;
        if (wr_page) slot_page[tgt]  <= pa_new;
        if (inc_free)      free_buffers <= free_buffers + 1'b1;
        else if (dec_free) free_buffers <= free_buffers - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      fill_buf         <= tgt;
      rd_blank         <= int'(req.word_offset) >= WORDS;
      rsp.found        <= found;
      rsp.chosen_index <= (tgt_ok && !err && found &&
                           (req.command == CMD_ACQ_IN || req.command == CMD_ACQ_PROG))
                          ? 2'(tgt) : 2'd0;
      rsp.bytes_copied <= copied;
      // a refused command on a valid buffer still reports that buffer
      rsp.page_address <= tgt_ok ? pa_new : 32'd0;
      rsp.buffer_state <= tgt_ok ? 2'(st_new) : 2'd0;
      rsp.free_count   <= 3'(free_buffers + CNT_W'(inc_free) - CNT_W'(dec_free));
      rsp.error        <= err;
      rsp.read_data    <= '0;
    end else if (state == S_READ) begin
      rsp.read_data <= rd_blank ? 64'd0 : merged;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppb_checker.sv @@
// ----------------------------------------------------------------------------
// ppb_checker
// Port-level checks of the buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ppb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        found,
  input wire logic [3:0]  bytes_copied,
  input wire logic [63:0] read_data,
  input wire logic [2:0]  free_count,
  input wire logic        error
);

  // a waiting result stays valid and holds its read data
  `CHK_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data))
  // one item at a time: no request taken while a result waits
  `CHK_SAME(a_one, clk, rst, rsp_valid, !req_ready)
  // free count never exceeds the pool
  `CHK_SAME(a_cnt, clk, rst, rsp_valid, free_count <= 3'd4)
  // a refused operation reports nothing found and nothing copied
  `CHK_SAME(a_err, clk, rst, rsp_valid && error, !found && bytes_copied == 4'd0)

endmodule

bind page_program_buffer_pool ppb_checker u_ppb_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .found        (rsp.found),
  .bytes_copied (rsp.bytes_copied),
  .read_data    (rsp.read_data),
  .free_count   (rsp.free_count),
  .error        (rsp.error)
);

`default_nettype wire

@@ bench/page_program_buffer_pool_tb.sv @@
// ----------------------------------------------------------------------------
// page_program_buffer_pool_tb
// Drives command items into the buffer pool with random idling on both
// channels, predicts every result item from a model of the pool and compares
// each field. A directed table comes first, then random buffer lifecycles and noise.
// ----------------------------------------------------------------------------
module page_program_buffer_pool_tb;
  import ppb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  buffer_index;
    logic [31:0] byte_address;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic        submit;
    logic [3:0]  word_offset;
  } op_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  chosen_index;
    logic [3:0]  bytes_copied;
    logic [31:0] page_address;
    logic [63:0] read_data;
    logic [1:0]  buffer_state;
    logic [2:0]  free_count;
    logic        error;
  } pool_result_t;

  typedef struct packed {
    op_item_t     op;
    logic         typed;
    pool_result_t want;
  } table_row_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppb_req_if req ();
  ppb_rsp_if rsp ();

  page_program_buffer_pool i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  slot_t       mdl_state [BUFFERS];
  logic [31:0] mdl_page [BUFFERS];
  logic [7:0]  mdl_bytes [BUFFERS][PAGE_BYTES];
  logic        mdl_blank [BUFFERS][PAGE_BYTES];
  int          mdl_free;

  pool_result_t pending_results[$];
  op_item_t     send_queue[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           idle_off = 1'b0;
  bit           done_sending = 1'b0;

  function automatic logic [31:0] page_base(logic [31:0] a);
    return a - (a % PAGE_BYTES);
  endfunction

  function automatic pool_result_t pool_predict(op_item_t op);
    pool_result_t r;
    int tgt, idx, off, n, pos;
    slot_t st;
    r = '0;
    tgt = -1;
    idx = int'(op.buffer_index);
    if (op.command == CMD_ACQ_IN || op.command == CMD_ACQ_PROG) begin
      for (int u = 0; u < BUFFERS; u++)
        if (mdl_state[u] == ((op.command == CMD_ACQ_IN) ? ST_FREE : ST_TOPROG)) tgt = u;
      if (tgt >= 0) begin
        r.found = 1'b1;
        r.chosen_index = 2'(tgt);
        if (op.command == CMD_ACQ_IN) begin
          for (int b = 0; b < PAGE_BYTES; b++) mdl_blank[tgt][b] = 1'b1;
          mdl_state[tgt] = ST_EMPTY;
          if (mdl_free > 0) mdl_free--;
        end
      end
    end else if (op.command <= CMD_READ) begin
      st = mdl_state[idx];
      tgt = idx;
      case (op.command)
        CMD_CHECK: begin
          if (st == ST_EMPTY) begin
            mdl_page[idx] = page_base(op.byte_address);
            r.found = 1'b1;
          end else if (st == ST_FILLING) begin
            r.found = (mdl_page[idx] == page_base(op.byte_address));
          end else begin
            r.error = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (st == ST_FREE || st == ST_TOPROG) begin
            r.error = 1'b1;
          end else begin
            if (st == ST_EMPTY) begin
              mdl_page[idx] = page_base(op.byte_address);
              mdl_state[idx] = ST_FILLING;
            end
            if (page_base(op.byte_address) == mdl_page[idx]) begin
              off = int'(op.byte_address % PAGE_BYTES);
              n = (op.byte_count > LANE_BYTES) ? LANE_BYTES : int'(op.byte_count);
              if (n > PAGE_BYTES - off) n = PAGE_BYTES - off;
              for (int i = 0; i < n; i++) begin
                mdl_bytes[idx][off + i] = op.write_data[8*i +: 8];
                mdl_blank[idx][off + i] = 1'b0;
              end
              r.bytes_copied = 4'(n);
            end
          end
        end
        CMD_RELEASE: begin
          if (op.submit) begin
            if (st == ST_FILLING) mdl_state[idx] = ST_TOPROG;
            else r.error = 1'b1;
          end else if (st == ST_FREE) begin
            r.error = 1'b1;
          end else begin
            mdl_state[idx] = ST_FREE;
            if (mdl_free < BUFFERS) mdl_free++;
          end
        end
        default: begin
          for (int i = 0; i < LANE_BYTES; i++) begin
            pos = int'(op.word_offset) * LANE_BYTES + i;
            if (pos < PAGE_BYTES)
              r.read_data[8*i +: 8] = mdl_blank[idx][pos] ? 8'hFF : mdl_bytes[idx][pos];
          end
        end
      endcase
    end else begin
      r.error = 1'b1;
    end
    if (tgt >= 0) begin
      r.page_address = mdl_page[tgt];
      r.buffer_state = mdl_state[tgt];
    end
    r.free_count = 3'(mdl_free);
    return r;
  endfunction

  function automatic op_item_t make_op(cmd_t c, int idx, logic [31:0] a, int cnt,
                                       logic [63:0] d, bit s, int w);
    op_item_t o;
    o.command = c;
    o.buffer_index = 2'(idx);
    o.byte_address = a;
    o.byte_count = 4'(cnt);
    o.write_data = d;
    o.submit = s;
    o.word_offset = 4'(w);
    return o;
  endfunction

  function automatic op_item_t random_op(cmd_t c, int idx, logic [31:0] page);
    op_item_t o;
    o = make_op(c, idx, {$urandom()}, $urandom_range(0, 15),
                {$urandom(), $urandom()}, $urandom_range(0, 1), $urandom_range(0, 15));
    // mostly stay on the claimed page, sometimes near its end
    if ($urandom_range(0, 9) < 8)
      o.byte_address = page + (($urandom_range(0, 3) == 0) ?
                       $urandom_range(PAGE_BYTES - 9, PAGE_BYTES - 1) :
                       $urandom_range(0, PAGE_BYTES - 1));
    if ($urandom_range(0, 3) != 0) o.byte_count = 4'($urandom_range(0, 8));
    return o;
  endfunction

  // stimulus generation
  task automatic build_random(int total);
    logic [31:0] pg;
    int k, idx, first;
    cmd_t c;
    k = 0;
    while (k < total) begin
      if ($urandom_range(0, 9) < 7) begin
        // a whole lifecycle: acquire, claim, fill, read, release
        first = send_queue.size();
        pg = page_base({$urandom()});
        idx = $urandom_range(0, BUFFERS - 1);
        send_queue.push_back(make_op(CMD_ACQ_IN, 0, 0, 0, 0, 0, 0));
        if ($urandom_range(0, 1)) send_queue.push_back(random_op(CMD_CHECK, idx, pg));
        repeat ($urandom_range(1, 8)) send_queue.push_back(random_op(CMD_WRITE, idx, pg));
        send_queue.push_back(random_op(CMD_CHECK, idx, pg));
        repeat ($urandom_range(1, 3)) send_queue.push_back(random_op(CMD_READ, idx, pg));
        send_queue.push_back(make_op(CMD_RELEASE, idx, 0, 0, 0, $urandom_range(0, 3) != 0, 0));
        if ($urandom_range(0, 1))
          send_queue.push_back(make_op(CMD_ACQ_PROG, 0, 0, 0, 0, 0, 0));
        if ($urandom_range(0, 2) == 0)
          send_queue.push_back(make_op(CMD_RELEASE, $urandom_range(0, BUFFERS - 1),
                                       0, 0, 0, 1'b0, 0));
        k += send_queue.size() - first;
      end else begin
        // noise, illegal commands included
        c = cmd_t'($urandom_range(0, 7));
        send_queue.push_back(random_op(c, $urandom_range(0, 3), page_base({$urandom()})));
        k++;
      end
    end
  endtask

  // directed table, results typed in where obvious
  table_row_t directed[$];

  task automatic add_row(op_item_t o, bit typed, pool_result_t w);
    table_row_t t;
    t.op = o;
    t.typed = typed;
    t.want = w;
    directed.push_back(t);
  endtask

  function automatic pool_result_t res(bit f, int ch, int cp, logic [31:0] pa,
                                       logic [63:0] rd, int st, int fc, bit e);
    pool_result_t r;
    r = '{f, 2'(ch), 4'(cp), pa, rd, 2'(st), 3'(fc), e};
    return r;
  endfunction

  task automatic build_directed();
    add_row(make_op(CMD_READ, 3, 0, 0, 0, 0, 15), 1, res(0, 0, 0, 0, 0, ST_FREE, 4, 0));
    add_row(make_op(CMD_WRITE, 0, 0, 8, '1, 0, 0), 1, res(0, 0, 0, 0, 0, ST_FREE, 4, 1));
    add_row(make_op(CMD_CHECK, 1, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, ST_FREE, 4, 1));
    add_row(make_op(CMD_RELEASE, 2, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, ST_FREE, 4, 1));
    add_row(make_op(CMD_RELEASE, 2, 0, 0, 0, 1, 0), 1, res(0, 0, 0, 0, 0, ST_FREE, 4, 1));
    add_row(make_op(CMD_ACQ_PROG, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 4, 0));
    add_row(make_op(cmd_t'(3'd6), 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0, 4, 1));
    add_row(make_op(cmd_t'(3'd7), 3, '1, 15, '1, 1, 15), 1, res(0, 0, 0, 0, 0, 0, 4, 1));
    add_row(make_op(CMD_ACQ_IN, 0, 0, 0, 0, 0, 0), 1, res(1, 3, 0, 0, 0, ST_EMPTY, 3, 0));
    add_row(make_op(CMD_READ, 3, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, '1, ST_EMPTY, 3, 0));
    add_row(make_op(CMD_CHECK, 3, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0);
    add_row(make_op(CMD_WRITE, 3, 32'hFFFF_FFF9, 15, 64'h0123_4567_89AB_CDEF, 0, 0), 0, '0);
    add_row(make_op(CMD_WRITE, 3, 32'h0000_0000, 8, '1, 0, 0), 0, '0);
    add_row(make_op(CMD_WRITE, 3, 32'hFFFF_FF80, 0, '1, 0, 0), 0, '0);
    add_row(make_op(CMD_CHECK, 3, 32'h1234_5678, 0, 0, 0, 0), 0, '0);
    add_row(make_op(CMD_READ, 3, 0, 0, 0, 0, 15), 0, '0);
    add_row(make_op(CMD_READ, 3, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_op(CMD_RELEASE, 3, 0, 0, 0, 1, 0), 0, '0);
    add_row(make_op(CMD_WRITE, 3, 32'hFFFF_FF80, 1, '1, 0, 0), 0, '0);
    add_row(make_op(CMD_RELEASE, 3, 0, 0, 0, 1, 0), 0, '0);
    add_row(make_op(CMD_ACQ_PROG, 0, 0, 0, 0, 0, 0), 0, '0);
    for (int i = 0; i < BUFFERS; i++)
      add_row(make_op(CMD_ACQ_IN, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_op(CMD_RELEASE, 3, 0, 0, 0, 0, 0), 0, '0);
  endtask

  // sender
  initial begin
    op_item_t o;
    int gap;
    req.valid <= 1'b0;
    req.command <= '0;
    req.buffer_index <= '0;
    req.byte_address <= '0;
    req.byte_count <= '0;
    req.write_data <= '0;
    req.submit <= 1'b0;
    req.word_offset <= '0;
    // model state after reset
    mdl_free = BUFFERS;
    for (int u = 0; u < BUFFERS; u++) begin
      mdl_state[u] = ST_FREE;
      mdl_page[u] = '0;
      for (int b = 0; b < PAGE_BYTES; b++) begin
        mdl_bytes[u][b] = '0;
        mdl_blank[u][b] = 1'b0;
      end
    end
    build_directed();
    foreach (directed[i]) send_queue.push_back(directed[i].op);
    build_random(1430);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < send_queue.size(); n++) begin
      o = send_queue[n];
      if (n == directed.size() + 400) begin
        // hold off until the pool has drained
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (n == send_queue.size() - 150) idle_off = 1'b1;
      if (!idle_off && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 6);
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req.valid <= 1'b1;
      req.command <= o.command;
      req.buffer_index <= o.buffer_index;
      req.byte_address <= o.byte_address;
      req.byte_count <= o.byte_count;
      req.write_data <= o.write_data;
      req.submit <= o.submit;
      req.word_offset <= o.word_offset;
      @(posedge clk);
      while (!req.ready) @(posedge clk);
      pending_results.push_back(pool_predict(o));
      if (n < directed.size() && directed[n].typed &&
          directed[n].want != pending_results[$]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: typed %h predicted %h", n, directed[n].want,
                   pending_results[$]);
      end
    end
    req.valid <= 1'b0;
    done_sending = 1'b1;
  end

  // receiver with random stalls
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with none expected");
        end else if (pending_results[0] != pool_result_t'{rsp.found, rsp.chosen_index,
                     rsp.bytes_copied, rsp.page_address, rsp.read_data,
                     rsp.buffer_state, rsp.free_count, rsp.error}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got f%b c%0d n%0d p%h d%h s%0d fc%0d e%b",
                     pending_results[0], rsp.found, rsp.chosen_index, rsp.bytes_copied,
                     rsp.page_address, rsp.read_data, rsp.buffer_state, rsp.free_count,
                     rsp.error);
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 5);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (done_sending);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ppb_pkg.sv
rtl/ppb_if.sv
rtl/ppb_ram.sv
rtl/ppb_lane.sv
rtl/page_program_buffer_pool.sv
rtl/ppb_checker.sv
bench/page_program_buffer_pool_tb.sv
